// File: rtl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants of the call profile accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpa_pkg;

    localparam int STACK_DEPTH_DEF   = 128;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ADDR_BITS_DEF     = 32;
    localparam int TIME_BITS_DEF     = 32;

    typedef enum logic [1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_STACK_FULL  = 3'd1;
    localparam logic [2:0] ST_STACK_EMPTY = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
    localparam logic [2:0] ST_SLOT_EMPTY  = 3'd4;

    typedef struct packed {
        op_t         op;
        logic [31:0] addr;
        logic [31:0] now;
        logic [5:0]  slot;
    } item_t;

endpackage

`default_nettype wire

// File: rtl/call_profile_accumulator_top.sv
// ----------------------------------------------------------------------------
// call_profile_accumulator_top
// Inclusive / exclusive function-call time profiler.
// ----------------------------------------------------------------------------
// Input beats (s_*) carry one operation in s_tuser: enter, exit, read slot
// or clear. Every beat yields exactly one result beat on m_*, carrying the
// status in m_tuser and the record plus stack depth in m_tdata.
// A two-entry queue takes beats while the execution side works.
// Enter, clear and a failed read go straight to the result; a read slot
// reads its record first. An exit steps through stack read, record
// lookup/read, record write and, with a parent frame, parent lookup/read
// and parent write, then the result. Queued beats wait for the beats
// ahead of them.
// Reset empties the stack and invalidates every table record at once; no
// clearing pass is needed. When m_tready is low the result holds and the
// sequencer waits before taking the next queued beat; the queue keeps
// accepting until it holds two beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module call_profile_accumulator_top #(
    parameter int STACK_DEPTH   = cpa_pkg::STACK_DEPTH_DEF,
    parameter int TABLE_ENTRIES = cpa_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = cpa_pkg::ADDR_BITS_DEF,
    parameter int TIME_BITS     = cpa_pkg::TIME_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,   // func_addr, now_ms, slot_index, pad
    input  wire logic [1:0]   s_tuser,   // opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // out_addr, total_ms, exclusive_ms, stack_depth
    output logic [2:0]        m_tuser    // status
);

    logic           q_valid;
    logic           q_pop;
    cpa_pkg::item_t q_item;
    logic [31:0]    out_addr;
    logic [31:0]    out_total;
    logic [31:0]    out_excl;
    logic [7:0]     out_depth;

    cpa_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    cpa_back #(
        .STACK_DEPTH(STACK_DEPTH), .TABLE_ENTRIES(TABLE_ENTRIES),
        .ADDR_BITS(ADDR_BITS), .TIME_BITS(TIME_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .out_status(m_tuser), .out_addr(out_addr),
        .out_total(out_total), .out_excl(out_excl), .out_depth(out_depth)
    );

    assign m_tdata = {out_depth, out_excl, out_total, out_addr};

endmodule

`default_nettype wire

// File: rtl/cpa_ram.sv
// ----------------------------------------------------------------------------
// cpa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/cpa_front.sv
// ----------------------------------------------------------------------------
// cpa_front
// Input side: accepts beats, decodes the operation, two-entry queue to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpa_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [71:0]   s_tdata,
    input  wire logic [1:0]    s_tuser,
    output logic               q_valid,
    output cpa_pkg::item_t     q_item,
    input  wire logic          q_pop
);

    cpa_pkg::item_t q_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    cpa_pkg::item_t in_item;

    always_comb
    begin
        in_item.op   = cpa_pkg::op_t'(s_tuser);
        in_item.addr = s_tdata[31:0];
        in_item.now  = s_tdata[63:32];
        in_item.slot = s_tdata[69:64];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push  ? ~wptr_reg : wptr_reg;
        rptr_next = q_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cpa_back.sv
// ----------------------------------------------------------------------------
// cpa_back
// Execution side: call stack, record table lookup and update, result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpa_back #(
    parameter int STACK_DEPTH   = cpa_pkg::STACK_DEPTH_DEF,
    parameter int TABLE_ENTRIES = cpa_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = cpa_pkg::ADDR_BITS_DEF,
    parameter int TIME_BITS     = cpa_pkg::TIME_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire cpa_pkg::item_t q_item,
    output logic                q_pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [2:0]          out_status,
    output logic [31:0]         out_addr,
    output logic [31:0]         out_total,
    output logic [31:0]         out_excl,
    output logic [7:0]          out_depth
);

    localparam int AW   = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int TW   = TIME_BITS;
    localparam int SIW  = $clog2(STACK_DEPTH);
    localparam int SPW  = $clog2(STACK_DEPTH + 1);
    localparam int TIW  = $clog2(TABLE_ENTRIES);
    localparam int SLW  = (TIW > 6) ? TIW : 6;
    localparam int DW   = (SPW > 8) ? SPW : 8;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EX1  = 7'b0000010,
        S_EX2  = 7'b0000100,
        S_EX3  = 7'b0001000,
        S_EX4  = 7'b0010000,
        S_RD   = 7'b0100000,
        S_HOLD = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [SPW-1:0]  sp_reg, sp_next;
    logic            valid_reg [TABLE_ENTRIES];
    logic            valid_next [TABLE_ENTRIES];
    logic [AW-1:0]   key_reg [TABLE_ENTRIES];
    logic [AW-1:0]   addr_reg, addr_next;
    logic [TW-1:0]   now_reg, now_next;
    logic [TW-1:0]   el_reg, el_next;
    logic [AW-1:0]   par_addr_reg, par_addr_next;
    logic [TIW-1:0]  me_idx_reg, me_idx_next;
    logic            me_ok_reg, me_ok_next;
    logic            me_new_reg, me_new_next;
    logic [TIW-1:0]  par_idx_reg, par_idx_next;
    logic            par_new_reg, par_new_next;
    logic [31:0]     tot_reg, tot_next;
    logic [31:0]     exc_reg, exc_next;
    logic [2:0]      st_reg, st_next;

    logic            ov_reg, ov_next;
    logic [2:0]      os_reg, os_next;
    logic [31:0]     oa_reg, oa_next;
    logic [31:0]     ot_reg, ot_next;
    logic [31:0]     oe_reg, oe_next;
    logic [7:0]      od_reg, od_next;

    // stack and table memories
    logic            sk_we;
    logic [SIW-1:0]  sk_waddr, sk_addr_raddr, sk_time_raddr;
    logic [AW-1:0]   sk_addr_rdata;
    logic [TW-1:0]   sk_time_rdata;
    logic            key_we;
    logic [TIW-1:0]  key_waddr, tab_raddr;
    logic [AW-1:0]   key_wdata, key_rdata;
    logic            dat_we;
    logic [TIW-1:0]  dat_waddr;
    logic [63:0]     dat_wdata, dat_rdata;

    // associative lookup
    logic [AW-1:0]   lk_key;
    logic            lk_hit, lk_free;
    logic [TIW-1:0]  lk_hit_idx, lk_free_idx;

    logic            out_free;
    logic [SLW-1:0]  slot_w;
    logic [TIW-1:0]  slot_idx;
    logic            slot_in_range;
    logic [DW-1:0]   depth_w;
    logic [31:0]     el32, mt, me, pe;

    cpa_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack_addr (
        .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(addr_next),
        .raddr(sk_addr_raddr), .rdata(sk_addr_rdata)
    );

    cpa_ram #(.WIDTH(TW), .DEPTH(STACK_DEPTH)) u_stack_time (
        .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(now_next),
        .raddr(sk_time_raddr), .rdata(sk_time_rdata)
    );

    cpa_ram #(.WIDTH(AW), .DEPTH(TABLE_ENTRIES)) u_key (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
        .raddr(tab_raddr), .rdata(key_rdata)
    );

    cpa_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_data (
        .clk(clk), .we(dat_we), .waddr(dat_waddr), .wdata(dat_wdata),
        .raddr(tab_raddr), .rdata(dat_rdata)
    );

    assign lk_key = (state_reg == S_EX3) ? par_addr_reg : addr_reg;

    // lowest index wins for both the match and the free slot
    always_comb
    begin
        lk_hit      = 1'b0;
        lk_free     = 1'b0;
        lk_hit_idx  = '0;
        lk_free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == lk_key)
            begin
                lk_hit     = 1'b1;
                lk_hit_idx = TIW'(i);
            end
            if (!valid_reg[i])
            begin
                lk_free     = 1'b1;
                lk_free_idx = TIW'(i);
            end
        end
    end

    assign out_free      = !ov_reg || m_tready;
    assign slot_w        = SLW'(q_item.slot);
    assign slot_idx      = slot_w[TIW-1:0];
    assign slot_in_range = ({5'b0, q_item.slot} < 11'(TABLE_ENTRIES));
    assign el32          = 32'(el_reg);

    always_comb
    begin
        state_next    = state_reg;
        sp_next       = sp_reg;
        valid_next    = valid_reg;
        addr_next     = addr_reg;
        now_next      = now_reg;
        el_next       = el_reg;
        par_addr_next = par_addr_reg;
        me_idx_next   = me_idx_reg;
        me_ok_next    = me_ok_reg;
        me_new_next   = me_new_reg;
        par_idx_next  = par_idx_reg;
        par_new_next  = par_new_reg;
        tot_next      = tot_reg;
        exc_next      = exc_reg;
        st_next       = st_reg;
        ov_next       = ov_reg && !m_tready;
        os_next       = os_reg;
        oa_next       = oa_reg;
        ot_next       = ot_reg;
        oe_next       = oe_reg;
        od_next       = od_reg;
        q_pop         = 1'b0;
        sk_we         = 1'b0;
        sk_waddr      = sp_reg[SIW-1:0];
        sk_time_raddr = SIW'(sp_reg - SPW'(1));
        sk_addr_raddr = SIW'(sp_reg - SPW'(2));
        key_we        = 1'b0;
        key_waddr     = lk_free_idx;
        key_wdata     = lk_key;
        dat_we        = 1'b0;
        dat_waddr     = me_idx_reg;
        dat_wdata     = '0;
        tab_raddr     = me_idx_reg;
        mt            = '0;
        me            = '0;
        pe            = '0;
        depth_w       = '0;

        case (state_reg)
            S_IDLE:
            begin
                tab_raddr = slot_idx;
                if (q_valid && out_free)
                begin
                    q_pop     = 1'b1;
                    addr_next = AW'(q_item.addr);
                    now_next  = TW'(q_item.now);
                    st_next   = cpa_pkg::ST_OK;
                    tot_next  = '0;
                    exc_next  = '0;
                    case (q_item.op)
                        cpa_pkg::OP_ENTER:
                        begin
                            if (sp_reg >= SPW'(STACK_DEPTH))
                            begin
                                st_next = cpa_pkg::ST_STACK_FULL;
                            end
                            else
                            begin
                                sk_we   = 1'b1;
                                sp_next = sp_reg + SPW'(1);
                            end
                            state_next = S_HOLD;
                        end
                        cpa_pkg::OP_EXIT:
                        begin
                            if (sp_reg == '0)
                            begin
                                st_next    = cpa_pkg::ST_STACK_EMPTY;
                                state_next = S_HOLD;
                            end
                            else
                            begin
                                sp_next    = sp_reg - SPW'(1);
                                state_next = S_EX1;
                            end
                        end
                        cpa_pkg::OP_READ:
                        begin
                            if (slot_in_range && valid_reg[slot_idx])
                            begin
                                state_next = S_RD;
                            end
                            else
                            begin
                                st_next    = cpa_pkg::ST_SLOT_EMPTY;
                                addr_next  = '0;
                                state_next = S_HOLD;
                            end
                        end
                        cpa_pkg::OP_CLEAR:
                        begin
                            for (int i = 0; i < TABLE_ENTRIES; i++)
                            begin
                                valid_next[i] = 1'b0;
                            end
                            addr_next  = '0;
                            state_next = S_HOLD;
                        end
                        default:
                        begin
                            state_next = S_HOLD;
                        end
                    endcase
                end
            end

            S_EX1:
            begin
                el_next       = now_reg - sk_time_rdata;
                par_addr_next = sk_addr_rdata;
                me_new_next   = 1'b0;
                me_ok_next    = 1'b1;
                if (lk_hit)
                begin
                    me_idx_next = lk_hit_idx;
                end
                else if (lk_free)
                begin
                    me_idx_next             = lk_free_idx;
                    me_new_next             = 1'b1;
                    valid_next[lk_free_idx] = 1'b1;
                    key_we                  = 1'b1;
                end
                else
                begin
                    me_ok_next = 1'b0;
                end
                tab_raddr  = me_idx_next;
                state_next = S_EX2;
            end

            S_EX2:
            begin
                if (me_ok_reg)
                begin
                    mt        = (me_new_reg ? 32'd0 : dat_rdata[63:32]) + el32;
                    me        = (me_new_reg ? 32'd0 : dat_rdata[31:0]) + el32;
                    dat_we    = 1'b1;
                    dat_wdata = {mt, me};
                    tot_next  = mt;
                    exc_next  = me;
                end
                else
                begin
                    st_next = cpa_pkg::ST_TABLE_FULL;
                end
                state_next = (sp_reg != '0) ? S_EX3 : S_HOLD;
            end

            S_EX3:
            begin
                par_new_next = 1'b0;
                state_next   = S_EX4;
                if (lk_hit)
                begin
                    par_idx_next = lk_hit_idx;
                end
                else if (lk_free)
                begin
                    par_idx_next            = lk_free_idx;
                    par_new_next            = 1'b1;
                    valid_next[lk_free_idx] = 1'b1;
                    key_we                  = 1'b1;
                end
                else
                begin
                    st_next    = cpa_pkg::ST_TABLE_FULL;
                    state_next = S_HOLD;
                end
                tab_raddr = par_idx_next;
            end

            S_EX4:
            begin
                mt        = par_new_reg ? 32'd0 : dat_rdata[63:32];
                pe        = (par_new_reg ? 32'd0 : dat_rdata[31:0]) - el32;
                dat_we    = 1'b1;
                dat_waddr = par_idx_reg;
                dat_wdata = {mt, pe};
                // a recursive call charges its own record as parent
                if (me_ok_reg && par_idx_reg == me_idx_reg)
                begin
                    exc_next = pe;
                end
                state_next = S_HOLD;
            end

            S_RD:
            begin
                addr_next  = key_rdata;
                tot_next   = dat_rdata[63:32];
                exc_next   = dat_rdata[31:0];
                state_next = S_HOLD;
            end

            S_HOLD:
            begin
                depth_w    = DW'(sp_reg);
                ov_next    = 1'b1;
                os_next    = st_reg;
                oa_next    = 32'(addr_reg);
                ot_next    = tot_reg;
                oe_next    = exc_reg;
                od_next    = depth_w[7:0];
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_reg[lk_free_idx] <= lk_key;
        end
        addr_reg     <= addr_next;
        now_reg      <= now_next;
        el_reg       <= el_next;
        par_addr_reg <= par_addr_next;
        me_idx_reg   <= me_idx_next;
        me_ok_reg    <= me_ok_next;
        me_new_reg   <= me_new_next;
        par_idx_reg  <= par_idx_next;
        par_new_reg  <= par_new_next;
        tot_reg      <= tot_next;
        exc_reg      <= exc_next;
        st_reg       <= st_next;
        os_reg       <= os_next;
        oa_reg       <= oa_next;
        ot_reg       <= ot_next;
        oe_reg       <= oe_next;
        od_reg       <= od_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            ov_reg    <= ov_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid   = ov_reg;
    assign out_status = os_reg;
    assign out_addr   = oa_reg;
    assign out_total  = ot_reg;
    assign out_excl   = oe_reg;
    assign out_depth  = od_reg;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE) && out_free)
        else $error("item taken while busy or output blocked");

    a_ex4_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EX4) |-> $past(state_reg) == S_EX3)
        else $error("parent update out of sequence");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |=> m_tvalid && (state_reg == S_IDLE))
        else $error("result not posted");

endmodule

`default_nettype wire
